// ----- hdl/kmst_pkg.sv -----
// ----------------------------------------------------------------------------
// kmst_pkg
// Shared types and constants for the Kruskal spanning-tree block.
// ----------------------------------------------------------------------------
package kmst_pkg;

    localparam int VTX_W = 6;
    localparam int WGT_W = 16;
    localparam int CFG_W = 7;

    localparam logic [WGT_W-1:0] NO_EDGE_WEIGHT = 16'hFFFF;
    localparam logic [CFG_W-1:0] VCOUNT_RESET   = 7'd64;

    // one stored edge: 28 bits
    typedef struct packed {
        logic [VTX_W-1:0] b;
        logic [VTX_W-1:0] e;
        logic [WGT_W-1:0] w;
    } t_edge;

    // controller -> datapath
    typedef struct packed {
        logic load;      // input word accepted
        logic clr_i;     // outer index back to 0
        logic rd_i;      // read entry i, j <= i + 1
        logic cur_load;  // capture entry i as current
        logic j_issue;   // read entry j, j++
        logic wb;        // write current to i, i++
        logic rd_edge;   // read sorted edge i
        logic edge_cap;  // capture edge, start root walk of begin
        logic walk_b;    // root walk step for begin
        logic walk_e;    // root walk step for end
        logic link;      // union if roots differ, i++
        logic finish;    // completion word, clear run state
    } t_kmst_cmd;

    // datapath -> controller
    typedef struct packed {
        logic sort_end;
        logic j_last;
        logic uf_end;
        logic walk_root;
        logic roots_differ;
        logic out_ready;
    } t_kmst_sts;

endpackage

// ----- hdl/kmst_ram.sv -----
// ----------------------------------------------------------------------------
// kmst_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module kmst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/kmst_ctrl.sv -----
// ----------------------------------------------------------------------------
// kmst_ctrl
// Sequencer: load, exchange sort, union-find walk, completion.
// ----------------------------------------------------------------------------
module kmst_ctrl
    import kmst_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_last_edge,
    input  t_kmst_sts i_sts,
    output t_kmst_cmd o_cmd,
    output logic      o_in_stall
);

    localparam logic [3:0] S_LOAD     = 4'd0;
    localparam logic [3:0] S_SI       = 4'd1;
    localparam logic [3:0] S_SI_WAIT  = 4'd2;
    localparam logic [3:0] S_SJ       = 4'd3;
    localparam logic [3:0] S_SJ_DRAIN = 4'd4;
    localparam logic [3:0] S_SI_WB    = 4'd5;
    localparam logic [3:0] S_UF_RD    = 4'd6;
    localparam logic [3:0] S_UF_EDGE  = 4'd7;
    localparam logic [3:0] S_UF_FB    = 4'd8;
    localparam logic [3:0] S_UF_FE    = 4'd9;
    localparam logic [3:0] S_UF_LINK  = 4'd10;
    localparam logic [3:0] S_DONE     = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_LOAD: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid && i_last_edge) begin
                    n_state = S_SI;
                end
            end
            S_SI: begin
                if (i_sts.sort_end) begin
                    o_cmd.clr_i = 1'b1;
                    n_state     = S_UF_RD;
                end else begin
                    o_cmd.rd_i = 1'b1;
                    n_state    = S_SI_WAIT;
                end
            end
            S_SI_WAIT: begin
                o_cmd.cur_load = 1'b1;
                n_state        = S_SJ;
            end
            S_SJ: begin
                o_cmd.j_issue = 1'b1;
                if (i_sts.j_last) begin
                    n_state = S_SJ_DRAIN;
                end
            end
            S_SJ_DRAIN: begin
                n_state = S_SI_WB;
            end
            S_SI_WB: begin
                o_cmd.wb = 1'b1;
                n_state  = S_SI;
            end
            S_UF_RD: begin
                if (i_sts.uf_end) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_edge = 1'b1;
                    n_state       = S_UF_EDGE;
                end
            end
            S_UF_EDGE: begin
                o_cmd.edge_cap = 1'b1;
                n_state        = S_UF_FB;
            end
            S_UF_FB: begin
                o_cmd.walk_b = 1'b1;
                if (i_sts.walk_root) begin
                    n_state = S_UF_FE;
                end
            end
            S_UF_FE: begin
                o_cmd.walk_e = 1'b1;
                if (i_sts.walk_root) begin
                    n_state = S_UF_LINK;
                end
            end
            S_UF_LINK: begin
                // wait for room only when an edge goes out
                if (!i_sts.roots_differ || i_sts.out_ready) begin
                    o_cmd.link = 1'b1;
                    n_state    = S_UF_RD;
                end
            end
            S_DONE: begin
                if (i_sts.out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_LOAD);

endmodule

// ----- hdl/kmst_dpath.sv -----
// ----------------------------------------------------------------------------
// kmst_dpath
// Edge store, sort compare/swap, parent store with root walk, output word.
// ----------------------------------------------------------------------------
module kmst_dpath
    import kmst_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 2048
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CFG_W-1:0] i_vertex_count,
    input  logic [VTX_W-1:0] i_edge_begin,
    input  logic [VTX_W-1:0] i_edge_end,
    input  logic [WGT_W-1:0] i_edge_weight,
    input  t_kmst_cmd        i_cmd,
    output t_kmst_sts        o_sts,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output logic [VTX_W-1:0] o_tree_begin,
    output logic [VTX_W-1:0] o_tree_end,
    output logic [WGT_W-1:0] o_tree_weight,
    output logic             o_edge_valid,
    output logic             o_is_last
);

    localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int VW = $clog2(MAX_VERTICES);

    // counters
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_j;
    logic [CW:0]   i_inc;

    // sort
    t_edge          r_cur;
    t_edge          r_edge;
    t_edge          edge_rdata;
    logic           r_cmp_vld;
    logic [AW-1:0]  r_cmp_idx;
    logic           swap;

    // edge RAM ports
    logic           e_wr_en;
    logic [AW-1:0]  e_wr_addr;
    t_edge          e_wr_data;
    logic           e_rd_en;
    logic [AW-1:0]  e_rd_addr;

    // union-find
    logic [MAX_VERTICES-1:0] r_pvalid;
    logic [VW-1:0]  r_par_addr;
    logic           r_par_hit;
    logic [VW-1:0]  r_rb;
    logic [VW-1:0]  r_re;
    logic [VW-1:0]  pram_rdata;
    logic [VW-1:0]  par;
    logic           par_root;
    logic           p_rd_en;
    logic [VW-1:0]  p_rd_addr;
    logic           p_wr_en;
    logic           differ;

    // input filter and output
    logic           store_ok;
    logic           out_ready;
    logic           out_edge;
    logic           r_out_valid;

    assign i_inc = {1'b0, r_i} + (CW + 1)'(1);

    assign store_ok = (i_edge_weight != NO_EDGE_WEIGHT)
                   && ({1'b0, i_edge_begin} < i_vertex_count)
                   && ({1'b0, i_edge_end} < i_vertex_count)
                   && (32'(i_edge_begin) < MAX_VERTICES)
                   && (32'(i_edge_end) < MAX_VERTICES)
                   && (r_count < CW'(MAX_EDGES));

    assign swap = r_cmp_vld && (r_cur.w > edge_rdata.w);

    // edge RAM write and read select
    always_comb begin
        e_wr_en   = 1'b0;
        e_wr_addr = r_count[AW-1:0];
        e_wr_data = r_cur;
        priority if (i_cmd.load) begin
            e_wr_en   = store_ok;
            e_wr_data = '{b: i_edge_begin, e: i_edge_end, w: i_edge_weight};
        end else if (swap) begin
            e_wr_en   = 1'b1;
            e_wr_addr = r_cmp_idx;
        end else if (i_cmd.wb) begin
            e_wr_en   = 1'b1;
            e_wr_addr = r_i[AW-1:0];
        end else begin
            e_wr_en = 1'b0;
        end
    end

    assign e_rd_en   = i_cmd.rd_i || i_cmd.rd_edge || i_cmd.j_issue;
    assign e_rd_addr = i_cmd.j_issue ? r_j[AW-1:0] : r_i[AW-1:0];

    kmst_ram #(
        .WIDTH ($bits(t_edge)),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .i_clk     (i_clk),
        .i_wr_en   (e_wr_en),
        .i_wr_addr (e_wr_addr),
        .i_wr_data (e_wr_data),
        .i_rd_en   (e_rd_en),
        .i_rd_addr (e_rd_addr),
        .o_rd_data (edge_rdata)
    );

    // parent: entry never written reads as its own index
    assign par      = r_par_hit ? pram_rdata : r_par_addr;
    assign par_root = (par == r_par_addr);
    assign differ   = (r_rb != r_re);

    always_comb begin
        p_rd_en   = 1'b0;
        p_rd_addr = par;
        priority if (i_cmd.edge_cap) begin
            p_rd_en   = 1'b1;
            p_rd_addr = VW'(edge_rdata.b);
        end else if (i_cmd.walk_b) begin
            p_rd_en   = 1'b1;
            p_rd_addr = par_root ? VW'(r_edge.e) : par;
        end else if (i_cmd.walk_e) begin
            p_rd_en   = !par_root;
        end else begin
            p_rd_en = 1'b0;
        end
    end

    assign p_wr_en = i_cmd.link && differ;

    kmst_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_VERTICES)
    ) u_parent_ram (
        .i_clk     (i_clk),
        .i_wr_en   (p_wr_en),
        .i_wr_addr (r_rb),
        .i_wr_data (r_re),
        .i_rd_en   (p_rd_en),
        .i_rd_addr (p_rd_addr),
        .o_rd_data (pram_rdata)
    );

    assign out_ready = !r_out_valid || !i_out_stall;
    assign out_edge  = i_cmd.link && differ;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_i         <= '0;
            r_cmp_vld   <= 1'b0;
            r_pvalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.j_issue;
            if (i_cmd.load && store_ok) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.clr_i || i_cmd.finish) begin
                r_i <= '0;
            end else if (i_cmd.wb || i_cmd.link) begin
                r_i <= i_inc[CW-1:0];
            end
            if (p_wr_en) begin
                r_pvalid[r_rb] <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_count  <= '0;
                r_pvalid <= '0;
            end
            if (out_edge || i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_i) begin
            r_j <= i_inc[CW-1:0];
        end else if (i_cmd.j_issue) begin
            r_j <= r_j + CW'(1);
        end
        r_cmp_idx <= r_j[AW-1:0];
        if (i_cmd.cur_load || swap) begin
            r_cur <= edge_rdata;
        end
        if (i_cmd.edge_cap) begin
            r_edge <= edge_rdata;
        end
        if (p_rd_en) begin
            r_par_addr <= p_rd_addr;
            r_par_hit  <= r_pvalid[p_rd_addr];
        end
        if (i_cmd.walk_b && par_root) begin
            r_rb <= par;
        end
        if (i_cmd.walk_e && par_root) begin
            r_re <= par;
        end
        if (out_edge) begin
            o_tree_begin  <= r_edge.b;
            o_tree_end    <= r_edge.e;
            o_tree_weight <= r_edge.w;
            o_edge_valid  <= 1'b1;
            o_is_last     <= 1'b0;
        end else if (i_cmd.finish) begin
            o_tree_begin  <= '0;
            o_tree_end    <= '0;
            o_tree_weight <= '0;
            o_edge_valid  <= 1'b0;
            o_is_last     <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;

    assign o_sts.sort_end     = (i_inc >= {1'b0, r_count});
    assign o_sts.j_last       = (({1'b0, r_j} + (CW + 1)'(1)) == {1'b0, r_count});
    assign o_sts.uf_end       = (r_i >= r_count);
    assign o_sts.walk_root    = par_root;
    assign o_sts.roots_differ = differ;
    assign o_sts.out_ready    = out_ready;

    // inner sort index stays inside the stored edges
    a_j_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.j_issue |-> (r_j < r_count))
        else $error("sort inner index past edge count");

    // write-back target is below the last entry
    a_wb_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wb |-> (i_inc < {1'b0, r_count}))
        else $error("sort write-back past edge count");

    // a tree edge never overwrites a word still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_edge || i_cmd.finish) |-> out_ready)
        else $error("output word overwritten");

    // run end leaves the store empty and all parents reset
    a_run_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> ((r_count == '0) && (r_pvalid == '0)))
        else $error("run state not cleared");

endmodule

// ----- hdl/kruskal_minimum_spanning_tree.sv -----
// ----------------------------------------------------------------------------
// kruskal_minimum_spanning_tree
// Order: edges load at one word per cycle; after the last edge the sort runs,
//   then the union-find pass over the sorted edges, then one completion word.
// Throughput: one graph at a time; inputs stall from the last edge to the
//   completion word. Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
//
// Kruskal minimum spanning forest over a streamed edge list.
//
// Flow:
//   load   - each accepted word is filtered (no-edge weight, endpoint beyond
//            the vertex limit, store full) and appended to the edge RAM.
//   sort   - exchange sort in place. Entry i sits in a register while entries
//            j = i+1 .. n-1 stream out of the edge RAM one per cycle; a
//            lighter entry is swapped into the register and the old one is
//            written back at j. Entry i is written back at the end of the
//            inner pass. The RAM read-to-compare path is one stage deep.
//   union  - for each sorted edge the root of each endpoint is found by
//            walking the parent RAM, one hop per cycle (no path compression).
//            When the roots differ, parent[root(begin)] <= root(end) and the
//            edge goes out as a tree word.
//   finish - one completion word (edge_valid 0, is_last 1), then the edge
//            count and the parent valid bits clear in the same cycle.
//
// Parent entries carry a valid bit each; an entry not yet written reads as
// its own index, so a clear only resets the valid bits.
//
// The output word sits in a register, so the next graph may begin loading
// while the completion word is still stalled downstream.
//
// vertex_count is written through the config channel, which is always ready;
// the user must change it only while the block is idle; nothing enforces it.
//
module kruskal_minimum_spanning_tree
    import kmst_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 2048
) (
    input  logic             i_clk,
    input  logic             i_rst_n,

    // config channel
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data,

    // edge input
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [VTX_W-1:0] i_edge_begin,
    input  logic [VTX_W-1:0] i_edge_end,
    input  logic [WGT_W-1:0] i_edge_weight,
    input  logic             i_last_edge,

    // tree output
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [VTX_W-1:0] o_tree_begin,
    output logic [VTX_W-1:0] o_tree_end,
    output logic [WGT_W-1:0] o_tree_weight,
    output logic             o_edge_valid,
    output logic             o_is_last
);

    logic [CFG_W-1:0] r_vertex_count;
    t_kmst_cmd        cmd;
    t_kmst_sts        sts;

    // config register; the user must write it only between runs (not enforced)
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= VCOUNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_vertex_count <= i_cfg_data;
        end
    end

    // sequencer
    kmst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_edge (i_last_edge),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall)
    );

    // storage, compare and output word
    kmst_dpath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_vertex_count (r_vertex_count),
        .i_edge_begin   (i_edge_begin),
        .i_edge_end     (i_edge_end),
        .i_edge_weight  (i_edge_weight),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_tree_begin   (o_tree_begin),
        .o_tree_end     (o_tree_end),
        .o_tree_weight  (o_tree_weight),
        .o_edge_valid   (o_edge_valid),
        .o_is_last      (o_is_last)
    );

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Kruskal spanning-tree block: streams edge lists
// (directed graphs, then random ones), predicts every tree word and the
// completion word, and compares what comes out field by field.
// ----------------------------------------------------------------------------
module testbench;

    import kmst_pkg::*;

    localparam int MAX_VTX     = 64;
    localparam int MAX_EDG     = 2048;
    localparam int RAND_ITEMS  = 420;
    localparam int SETTLE      = 8;        // idle margin once the completion word is out
    localparam int TAIL_CYCLES = 40;
    localparam int CYCLE_LIMIT = 500000;

    // one word on the tree output
    typedef struct packed {
        logic [VTX_W-1:0] b;
        logic [VTX_W-1:0] e;
        logic [WGT_W-1:0] w;
        logic             edge_valid;
        logic             is_last;
    } t_tree_word;

    // what a directed row does and how its results are known
    typedef enum logic [1:0] {
        ROW_SET_VCOUNT,   // config write, w holds the vertex count
        ROW_PREDICT,      // edge word, results from the predictor
        ROW_ONLY_DONE,    // last word, result is the completion word alone
        ROW_SINGLE_TREE   // last word, result is this edge then completion
    } t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        logic [VTX_W-1:0] b;
        logic [VTX_W-1:0] e;
        logic [WGT_W-1:0] w;
        logic             last;
    } t_stim_row;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    localparam int PLAN_ROWS = 25;

    // directed graphs: extremes after reset, self loop, ties and repeats,
    // vertex limits 2, 1, 0 and 127, then back to the reset size
    t_stim_row directed_plan [PLAN_ROWS] = '{
        '{ROW_ONLY_DONE,   6'd0,  6'd0,  16'hFFFF, 1'b1},
        '{ROW_SINGLE_TREE, 6'd0,  6'd63, 16'd0,    1'b1},
        '{ROW_SINGLE_TREE, 6'd63, 6'd0,  16'hFFFE, 1'b1},
        '{ROW_ONLY_DONE,   6'd5,  6'd5,  16'd100,  1'b1},
        '{ROW_PREDICT,     6'd1,  6'd2,  16'd30,   1'b0},
        '{ROW_PREDICT,     6'd2,  6'd3,  16'd10,   1'b0},
        '{ROW_PREDICT,     6'd1,  6'd3,  16'd20,   1'b0},
        '{ROW_PREDICT,     6'd2,  6'd1,  16'd5,    1'b0},
        '{ROW_PREDICT,     6'd3,  6'd4,  16'd10,   1'b0},
        '{ROW_PREDICT,     6'd4,  6'd1,  16'd10,   1'b1},
        '{ROW_SET_VCOUNT,  6'd0,  6'd0,  16'd2,    1'b0},
        '{ROW_PREDICT,     6'd0,  6'd1,  16'd7,    1'b0},
        '{ROW_PREDICT,     6'd1,  6'd2,  16'd9,    1'b0},
        '{ROW_PREDICT,     6'd1,  6'd0,  16'd3,    1'b1},
        '{ROW_ONLY_DONE,   6'd0,  6'd2,  16'd4,    1'b1},
        '{ROW_SET_VCOUNT,  6'd0,  6'd0,  16'd1,    1'b0},
        '{ROW_PREDICT,     6'd0,  6'd0,  16'd12,   1'b0},
        '{ROW_ONLY_DONE,   6'd0,  6'd1,  16'd5,    1'b1},
        '{ROW_SET_VCOUNT,  6'd0,  6'd0,  16'd0,    1'b0},
        '{ROW_ONLY_DONE,   6'd0,  6'd0,  16'd1,    1'b1},
        '{ROW_SET_VCOUNT,  6'd0,  6'd0,  16'd127,  1'b0},
        '{ROW_PREDICT,     6'd62, 6'd63, 16'hFFFE, 1'b0},
        '{ROW_PREDICT,     6'd0,  6'd63, 16'd0,    1'b0},
        '{ROW_PREDICT,     6'd63, 6'd62, 16'd1,    1'b1},
        '{ROW_SET_VCOUNT,  6'd0,  6'd0,  16'd64,   1'b0}
    };

    // ------------------------------------------------------------------------
    // DUT ports
    // ------------------------------------------------------------------------
    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data;
    logic             i_in_valid;
    logic             o_in_stall;
    logic [VTX_W-1:0] i_edge_begin;
    logic [VTX_W-1:0] i_edge_end;
    logic [WGT_W-1:0] i_edge_weight;
    logic             i_last_edge;
    logic             o_out_valid;
    logic             i_out_stall;
    logic [VTX_W-1:0] o_tree_begin;
    logic [VTX_W-1:0] o_tree_end;
    logic [WGT_W-1:0] o_tree_weight;
    logic             o_edge_valid;
    logic             o_is_last;

    kruskal_minimum_spanning_tree DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_edge_begin  (i_edge_begin),
        .i_edge_end    (i_edge_end),
        .i_edge_weight (i_edge_weight),
        .i_last_edge   (i_last_edge),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_tree_begin  (o_tree_begin),
        .o_tree_end    (o_tree_end),
        .o_tree_weight (o_tree_weight),
        .o_edge_valid  (o_edge_valid),
        .o_is_last     (o_is_last)
    );

    // 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: stored edges, union-find parents, vertex limit
    // ------------------------------------------------------------------------
    t_edge            held_edges [MAX_EDG];
    int unsigned      held_count = 0;
    logic [VTX_W-1:0] parent_of [MAX_VTX];
    logic [CFG_W-1:0] vcount_now = VCOUNT_RESET;

    t_tree_word       tree_expect [$];     // tree words still owed by the block
    int unsigned      mismatches = 0;
    int unsigned      send_idle_pct = 0;
    int unsigned      recv_stall_pct = 0;
    int unsigned      cycle_count = 0;

    function automatic void clear_forest();
        for (int v = 0; v < MAX_VTX; v++)
            parent_of[v] = v[VTX_W-1:0];
    endfunction

    // no path compression; hop cap only guards against a broken forest
    function automatic logic [VTX_W-1:0] find_root(input logic [VTX_W-1:0] v);
        int hops;
        hops = 0;
        while (parent_of[v] != v && hops < MAX_VTX) begin
            v = parent_of[v];
            hops++;
        end
        return v;
    endfunction

    // Takes one accepted edge word. On the last word: exchange sort by weight
    // (not stable, ties keep the swap pattern of the block), then Kruskal with
    // union-find, pushing each tree word and the completion word if owe_words is set.
    function automatic void grow_forest(input t_edge ed, input logic last,
                                        input logic owe_words);
        int unsigned      lim;
        int unsigned      n_tree;
        t_edge            tmp;
        logic [VTX_W-1:0] rb;
        logic [VTX_W-1:0] re;
        lim = (vcount_now > MAX_VTX) ? MAX_VTX : 32'(vcount_now);
        if (ed.w != NO_EDGE_WEIGHT && ed.b < lim && ed.e < lim && held_count < MAX_EDG) begin
            held_edges[held_count] = ed;
            held_count++;
        end
        if (!last)
            return;
        for (int i = 0; i + 1 < held_count; i++)
            for (int j = i + 1; j < held_count; j++)
                if (held_edges[i].w > held_edges[j].w) begin
                    tmp           = held_edges[i];
                    held_edges[i] = held_edges[j];
                    held_edges[j] = tmp;
                end
        n_tree = 0;
        for (int i = 0; i < held_count; i++) begin
            rb = find_root(held_edges[i].b);
            re = find_root(held_edges[i].e);
            if (rb != re && n_tree < MAX_VTX - 1) begin
                parent_of[rb] = re;
                if (owe_words)
                    tree_expect.push_back('{held_edges[i].b, held_edges[i].e,
                                            held_edges[i].w, 1'b1, 1'b0});
                n_tree++;
            end
        end
        if (owe_words)
            tree_expect.push_back('{'0, '0, '0, 1'b0, 1'b1});
        held_count = 0;
        clear_forest();
    endfunction

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    // Optional gap with valid low, then hold the word until not stalled.
    // Valid stays high after acceptance; the next call either reloads it or
    // drops it, so it is never lowered and raised in one step.
    task automatic send_edge(input t_edge ed, input logic last);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_edge_begin  <= ed.b;
        i_edge_end    <= ed.e;
        i_edge_weight <= ed.w;
        i_last_edge   <= last;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    // all owed words out, then the SETTLE idle margin
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (tree_expect.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_vcount(input logic [CFG_W-1:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        vcount_now  = value;
    endtask

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SEND: begin
                send_idle_pct  = 71;
                recv_stall_pct = 0;
            end
            IDLE_RECV: begin
                send_idle_pct  = 0;
                recv_stall_pct = 71;
            end
            default: begin
                send_idle_pct  = 16;
                recv_stall_pct = 16;
            end
        endcase
    endtask

    // receiver stall, redrawn every cycle
    always @(posedge i_clk)
        i_out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);

    // ------------------------------------------------------------------------
    // Output check: every accepted word against the oldest owed word
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : tree_check
        t_tree_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (tree_expect.size() == 0) begin
                $error("tree word with none owed: begin %0d end %0d weight %0d",
                       o_tree_begin, o_tree_end, o_tree_weight);
                mismatches++;
            end else begin
                want = tree_expect.pop_front();
                if (o_tree_begin !== want.b) begin
                    $error("tree_begin: expected %0d, got %0d", want.b, o_tree_begin);
                    mismatches++;
                end
                if (o_tree_end !== want.e) begin
                    $error("tree_end: expected %0d, got %0d", want.e, o_tree_end);
                    mismatches++;
                end
                if (o_tree_weight !== want.w) begin
                    $error("tree_weight: expected %0d, got %0d", want.w, o_tree_weight);
                    mismatches++;
                end
                if (o_edge_valid !== want.edge_valid) begin
                    $error("edge_valid: expected %0d, got %0d", want.edge_valid, o_edge_valid);
                    mismatches++;
                end
                if (o_is_last !== want.is_last) begin
                    $error("is_last: expected %0d, got %0d", want.is_last, o_is_last);
                    mismatches++;
                end
            end
        end
    end

    // hang guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("kruskal_minimum_spanning_tree: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_stim_row   row;
        t_edge       ed;
        int unsigned sent;
        int unsigned graph_idx;
        int unsigned n_edges;
        int unsigned span;
        int unsigned pick;
        logic        last;

        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        i_in_valid    <= 1'b0;
        i_edge_begin  <= '0;
        i_edge_end    <= '0;
        i_edge_weight <= '0;
        i_last_edge   <= 1'b0;
        i_out_stall   <= 1'b0;
        clear_forest();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed graphs, no idling
        set_idling(IDLE_NONE);
        for (int r = 0; r < PLAN_ROWS; r++) begin
            row = directed_plan[r];
            if (row.kind == ROW_SET_VCOUNT) begin
                write_vcount(row.w[CFG_W-1:0]);
            end else begin
                ed = '{row.b, row.e, row.w};
                send_edge(ed, row.last);
                grow_forest(ed, row.last, row.kind == ROW_PREDICT);
                if (row.kind == ROW_SINGLE_TREE)
                    tree_expect.push_back('{row.b, row.e, row.w, 1'b1, 1'b0});
                if (row.kind != ROW_PREDICT)
                    tree_expect.push_back('{'0, '0, '0, 1'b0, 1'b1});
            end
        end

        // random graphs; idling mode rotates every three graphs, the
        // vertex limit changes now and then between graphs
        sent      = 0;
        graph_idx = 0;
        while (sent < RAND_ITEMS) begin
            set_idling(t_idle_mode'((graph_idx / 3) % 4));
            if ($urandom_range(2) == 0) begin
                pick = $urandom_range(9);
                case (pick)
                    0:       write_vcount(7'd0);
                    1:       write_vcount(7'd1);
                    2:       write_vcount(7'd2);
                    3:       write_vcount(7'd127);
                    4:       write_vcount(7'd64);
                    5:       write_vcount(CFG_W'($urandom_range(127)));
                    default: write_vcount(CFG_W'($urandom_range(3, 64)));
                endcase
            end
            // mostly small graphs, a few larger ones
            n_edges = ($urandom_range(9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
            span    = (vcount_now > MAX_VTX) ? MAX_VTX : 32'(vcount_now);
            if (span == 0)
                span = MAX_VTX;
            for (int k = 0; k < n_edges; k++) begin
                // endpoints inside the limit, with some out-of-range noise
                if ($urandom_range(9) == 0) begin
                    ed.b = VTX_W'($urandom_range(63));
                    ed.e = VTX_W'($urandom_range(63));
                end else begin
                    ed.b = VTX_W'($urandom_range(span - 1));
                    ed.e = VTX_W'($urandom_range(span - 1));
                end
                // narrow weights for ties, plus no-edge and the extremes
                pick = $urandom_range(99);
                if (pick < 40)
                    ed.w = WGT_W'($urandom_range(15));
                else if (pick < 45)
                    ed.w = NO_EDGE_WEIGHT;
                else if (pick < 50)
                    ed.w = ($urandom_range(1) == 0) ? 16'd0 : 16'hFFFE;
                else
                    ed.w = WGT_W'($urandom_range(16'hFFFF));
                last = (k == n_edges - 1);
                send_edge(ed, last);
                grow_forest(ed, last, 1'b1);
                sent++;
            end
            graph_idx++;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("kruskal_minimum_spanning_tree: match");
        else
            $display("kruskal_minimum_spanning_tree: mismatch");
        $finish;
    end

endmodule
